### sv/bted_pkg.sv
// ----------------------------------------------------------------------------
// bted_pkg
// Shared types and constants of the button event detector: register map,
// configuration bundle, per-channel state word and result word.
// ----------------------------------------------------------------------------
package bted_pkg;

	localparam int CH_W        = 3;
	localparam int CH_SPAN     = 1 << CH_W;
	localparam int TIME_W      = 32;
	localparam int MS_W        = 16;
	localparam int MASK_W      = 8;
	localparam int DATA_W      = 32;
	localparam int PADDR_W     = 5;
	localparam int CHANNELS_DEF = 8;

	localparam logic [MS_W-1:0]   DEBOUNCE_RST     = 16'd50;
	localparam logic [MS_W-1:0]   LONG_PRESS_RST   = 16'd1000;
	localparam logic [MS_W-1:0]   DOUBLE_CLICK_RST = 16'd500;
	localparam logic [MASK_W-1:0] LP_ENABLE_RST    = 8'hFF;

	typedef enum logic [2:0] {
		REG_DEBOUNCE      = 3'd0,
		REG_ACTIVE_HIGH   = 3'd1,
		REG_OVR_ENABLE    = 3'd2,
		REG_OVR_VALUE     = 3'd3,
		REG_LONG_PRESS    = 3'd4,
		REG_LP_ENABLE     = 3'd5,
		REG_DOUBLE_CLICK  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [MS_W-1:0]   debounce_ms;
		logic [MASK_W-1:0] active_high_mask;
		logic [MASK_W-1:0] override_enable_mask;
		logic [MASK_W-1:0] override_value_mask;
		logic [MS_W-1:0]   long_press_ms;
		logic [MASK_W-1:0] long_press_enable_mask;
		logic [MS_W-1:0]   double_click_ms;
	} cfg_t;

	// Per-channel state; the previous debounced level always equals the
	// stored stable level, so it is not kept separately.
	typedef struct packed {
		logic              stable;
		logic              last;
		logic [TIME_W-1:0] change_time;
		logic [TIME_W-1:0] press_time;
		logic [TIME_W-1:0] release_time;
		logic              latched;
	} entry_t;

	typedef struct packed {
		logic [CH_W-1:0] channel_out;
		logic            stable_active;
		logic            pressed;
		logic            released;
		logic            double_click;
		logic            long_press;
	} result_t;

endpackage

### sv/bted_sample_if.sv
// ----------------------------------------------------------------------------
// bted_sample_if
// Valid/ready channel carrying one pin sample.
// ----------------------------------------------------------------------------
interface bted_sample_if
	import bted_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CH_W-1:0]   channel;
	logic              raw_level;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, channel, raw_level, now_ms, input ready);
	modport sink   (input valid, channel, raw_level, now_ms, output ready);
endinterface

### sv/bted_event_if.sv
// ----------------------------------------------------------------------------
// bted_event_if
// Valid/ready channel carrying one debounced result with its event flags.
// ----------------------------------------------------------------------------
interface bted_event_if
	import bted_pkg::*;
();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] channel_out;
	logic            stable_active;
	logic            pressed;
	logic            released;
	logic            double_click;
	logic            long_press;

	modport source (output valid, channel_out, stable_active, pressed, released,
		double_click, long_press, input ready);
	modport sink   (input valid, channel_out, stable_active, pressed, released,
		double_click, long_press, output ready);
endinterface

### sv/bted_regs.sv
// ----------------------------------------------------------------------------
// bted_regs
// APB register file holding the timing windows and per-channel masks.
// ----------------------------------------------------------------------------
module bted_regs
	import bted_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr     = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms            <= DEBOUNCE_RST;
			cfg_q.active_high_mask       <= '0;
			cfg_q.override_enable_mask   <= '0;
			cfg_q.override_value_mask    <= '0;
			cfg_q.long_press_ms          <= LONG_PRESS_RST;
			cfg_q.long_press_enable_mask <= LP_ENABLE_RST;
			cfg_q.double_click_ms        <= DOUBLE_CLICK_RST;
		end else if (wr) begin
			case (idx)
				REG_DEBOUNCE:     cfg_q.debounce_ms            <= pwdata[MS_W-1:0];
				REG_ACTIVE_HIGH:  cfg_q.active_high_mask       <= pwdata[MASK_W-1:0];
				REG_OVR_ENABLE:   cfg_q.override_enable_mask   <= pwdata[MASK_W-1:0];
				REG_OVR_VALUE:    cfg_q.override_value_mask    <= pwdata[MASK_W-1:0];
				REG_LONG_PRESS:   cfg_q.long_press_ms          <= pwdata[MS_W-1:0];
				REG_LP_ENABLE:    cfg_q.long_press_enable_mask <= pwdata[MASK_W-1:0];
				REG_DOUBLE_CLICK: cfg_q.double_click_ms        <= pwdata[MS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_DEBOUNCE:     prdata = {{(DATA_W-MS_W){1'b0}}, cfg_q.debounce_ms};
			REG_ACTIVE_HIGH:  prdata = {{(DATA_W-MASK_W){1'b0}}, cfg_q.active_high_mask};
			REG_OVR_ENABLE:   prdata = {{(DATA_W-MASK_W){1'b0}}, cfg_q.override_enable_mask};
			REG_OVR_VALUE:    prdata = {{(DATA_W-MASK_W){1'b0}}, cfg_q.override_value_mask};
			REG_LONG_PRESS:   prdata = {{(DATA_W-MS_W){1'b0}}, cfg_q.long_press_ms};
			REG_LP_ENABLE:    prdata = {{(DATA_W-MASK_W){1'b0}},
				cfg_q.long_press_enable_mask};
			REG_DOUBLE_CLICK: prdata = {{(DATA_W-MS_W){1'b0}}, cfg_q.double_click_ms};
			default:          prdata = '0;
		endcase
	end

endmodule

### sv/multi_channel_button_event_detector.sv
// ----------------------------------------------------------------------------
// multi_channel_button_event_detector
// Debounce plus press, release, double click and long press per channel.
// ----------------------------------------------------------------------------
// Takes one sample per clock while the result side is ready and returns one
// result per sample, through the stage 1 registers and then the output
// register. The per-channel state word sits in a memory with one registered
// read port and one write port: the read is issued at the sample transfer,
// the updated word is written back when stage 1 advances, and the last
// written word is forwarded when the next sample hits the same channel, so
// back-to-back samples of one channel need no bubble. A valid flop per entry
// makes unwritten channels read as their reset state, so no clearing pass
// runs after reset. Samples for channels at or above CHANNELS return the
// channel number with all other fields zero and leave state alone.
module multi_channel_button_event_detector
	import bted_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	bted_sample_if.sink        samples,
	bted_event_if.source       events,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	localparam int DEPTH = (CHANNELS < CH_SPAN) ? CHANNELS : CH_SPAN;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cfg_t cfg;

	bted_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	entry_t mem [DEPTH];
	logic [DEPTH-1:0] valid_q;

	logic              s1_valid_q;
	logic [CH_W-1:0]   ch_s1;
	logic              raw_s1;
	logic [TIME_W-1:0] now_s1;
	entry_t            rd_s1;

	entry_t        wr_q;
	logic [AW-1:0] wr_idx_q;
	logic          wr_valid_q;

	logic    out_valid_q;
	result_t res_q;

	logic          acc;
	logic          s1_adv;
	logic          wr_en;
	logic [AW-1:0] idx_s1;
	logic          hit_s1;
	logic          fwd;
	entry_t        cur;
	entry_t        nxt;
	result_t       res;

	logic              lvl;
	logic              state;
	logic              pressed;
	logic              released;
	logic              dbl;
	logic              lng;
	logic              latched1;
	logic [TIME_W-1:0] since_chg;
	logic [TIME_W-1:0] since_rel;
	logic [TIME_W-1:0] since_press;

	assign s1_adv        = !out_valid_q || events.ready;
	assign samples.ready = !s1_valid_q || s1_adv;
	assign acc           = samples.valid && samples.ready;

	assign idx_s1 = ch_s1[AW-1:0];
	assign hit_s1 = {{(32-CH_W){1'b0}}, ch_s1} < 32'(DEPTH);
	assign wr_en  = s1_valid_q && s1_adv && hit_s1;
	assign fwd    = wr_valid_q && (wr_idx_q == idx_s1);

	// Stage 1: pick the current state word, then run debounce and events.
	always_comb begin
		if (!valid_q[idx_s1]) begin
			cur = '0;
		end else if (fwd) begin
			cur = wr_q;
		end else begin
			cur = rd_s1;
		end

		nxt = cur;
		if (cfg.override_enable_mask[ch_s1]) begin
			lvl             = cfg.override_value_mask[ch_s1];
			nxt.stable      = lvl;
			nxt.last        = lvl;
			nxt.change_time = now_s1;
		end else begin
			lvl = cfg.active_high_mask[ch_s1] ? raw_s1 : !raw_s1;
			if (!valid_q[idx_s1]) begin
				nxt.stable      = lvl;
				nxt.last        = lvl;
				nxt.change_time = now_s1;
			end else begin
				nxt.last = lvl;
				if (lvl != cur.last) begin
					nxt.change_time = now_s1;
				end
			end
		end
		since_chg = now_s1 - nxt.change_time;
		if (since_chg >= {{(TIME_W-MS_W){1'b0}}, cfg.debounce_ms}) begin
			nxt.stable = lvl;
		end

		state    = nxt.stable;
		pressed  = state && !cur.stable;
		released = !state && cur.stable;

		since_rel = now_s1 - cur.release_time;
		dbl       = pressed && (since_rel <= {{(TIME_W-MS_W){1'b0}}, cfg.double_click_ms});
		if (pressed) begin
			nxt.press_time = now_s1;
		end
		latched1 = cur.latched && !pressed;
		if (released) begin
			nxt.release_time = now_s1;
		end

		since_press = now_s1 - nxt.press_time;
		lng = state && (cfg.long_press_ms != '0) && cfg.long_press_enable_mask[ch_s1]
			&& !latched1
			&& (since_press >= {{(TIME_W-MS_W){1'b0}}, cfg.long_press_ms});
		nxt.latched = latched1 || lng;

		res.channel_out   = ch_s1;
		res.stable_active = hit_s1 && state;
		res.pressed       = hit_s1 && pressed;
		res.released      = hit_s1 && released;
		res.double_click  = hit_s1 && dbl;
		res.long_press    = hit_s1 && lng;
	end

	// Memory: registered read at the sample transfer, write-back from stage 1.
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1 <= mem[samples.channel[AW-1:0]];
		end
		if (wr_en) begin
			mem[idx_s1] <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ch_s1  <= samples.channel;
			raw_s1 <= samples.raw_level;
			now_s1 <= samples.now_ms;
		end
		if (wr_en) begin
			wr_q     <= nxt;
			wr_idx_q <= idx_s1;
		end
		if (s1_valid_q && s1_adv) begin
			res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			wr_valid_q  <= 1'b0;
			valid_q     <= '0;
		end else begin
			if (acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_valid_q && s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (events.ready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en) begin
				wr_valid_q      <= 1'b1;
				valid_q[idx_s1] <= 1'b1;
			end
		end
	end

	assign events.valid         = out_valid_q;
	assign events.channel_out   = res_q.channel_out;
	assign events.stable_active = res_q.stable_active;
	assign events.pressed       = res_q.pressed;
	assign events.released      = res_q.released;
	assign events.double_click  = res_q.double_click;
	assign events.long_press    = res_q.long_press;

`ifndef SYNTHESIS
	a_wr_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> valid_q[$past(idx_s1)])
		else $error("write-back did not mark its entry valid");

	a_press_xor_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.pressed && res_q.released))
		else $error("press and release reported together");

	a_dbl_needs_press: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.double_click |-> res_q.pressed && res_q.stable_active)
		else $error("double click without a press");

	a_long_needs_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.long_press |-> res_q.stable_active)
		else $error("long press on an inactive channel");

	a_stage_to_output: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && s1_adv |=> out_valid_q)
		else $error("stage 1 advanced without loading the output register");
`endif

endmodule

### test/bted_event_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bted_event_checker
// Watches the sample, event and register ports of the button event detector.
// Mirrors every register write, predicts the result of each sample transfer
// from its own copy of the per-channel debounce and event state, and compares
// each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module bted_event_checker
	import bted_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	bted_sample_if             samples,
	bted_event_if              events,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output int                 mismatches,
	output int                 in_flight
);

	cfg_t              cfg;
	logic              ch_seen      [CH_SPAN];
	logic              ch_stable    [CH_SPAN];
	logic              ch_last      [CH_SPAN];
	logic              ch_prior     [CH_SPAN];
	logic              ch_latched   [CH_SPAN];
	logic [TIME_W-1:0] ch_change_t  [CH_SPAN];
	logic [TIME_W-1:0] ch_press_t   [CH_SPAN];
	logic [TIME_W-1:0] ch_release_t [CH_SPAN];
	result_t           expected_events [$];

	// Advance one channel by one sample and return its debounced level and events.
	function automatic result_t detect_events(logic [CH_W-1:0] ch, logic raw,
		logic [TIME_W-1:0] now);
		result_t           res;
		logic              level;
		logic [TIME_W-1:0] held;
		res = '0;
		res.channel_out = ch;
		if (int'(ch) >= CHANNELS)
			return res;
		if (cfg.override_enable_mask[ch]) begin
			level = cfg.override_value_mask[ch];
			ch_seen[ch] = 1'b1;
			ch_stable[ch] = level;
			ch_last[ch] = level;
			ch_change_t[ch] = now;
		end else begin
			level = cfg.active_high_mask[ch] ? raw : ~raw;
			if (!ch_seen[ch]) begin
				ch_seen[ch] = 1'b1;
				ch_stable[ch] = level;
				ch_last[ch] = level;
				ch_change_t[ch] = now;
			end else begin
				if (level != ch_last[ch]) begin
					ch_last[ch] = level;
					ch_change_t[ch] = now;
				end
				held = now - ch_change_t[ch];
				if (held >= TIME_W'(cfg.debounce_ms))
					ch_stable[ch] = level;
			end
		end
		res.stable_active = ch_stable[ch];
		res.pressed = ch_stable[ch] & ~ch_prior[ch];
		res.released = ~ch_stable[ch] & ch_prior[ch];
		if (res.pressed) begin
			held = now - ch_release_t[ch];
			res.double_click = (held <= TIME_W'(cfg.double_click_ms));
			ch_press_t[ch] = now;
			ch_latched[ch] = 1'b0;
		end
		if (res.released)
			ch_release_t[ch] = now;
		held = now - ch_press_t[ch];
		if (res.stable_active && cfg.long_press_ms != '0 && cfg.long_press_enable_mask[ch]
			&& !ch_latched[ch] && held >= TIME_W'(cfg.long_press_ms)) begin
			res.long_press = 1'b1;
			ch_latched[ch] = 1'b1;
		end
		ch_prior[ch] = ch_stable[ch];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		result_t got;
		if (!arst_n) begin
			cfg.debounce_ms = DEBOUNCE_RST;
			cfg.active_high_mask = '0;
			cfg.override_enable_mask = '0;
			cfg.override_value_mask = '0;
			cfg.long_press_ms = LONG_PRESS_RST;
			cfg.long_press_enable_mask = LP_ENABLE_RST;
			cfg.double_click_ms = DOUBLE_CLICK_RST;
			for (int i = 0; i < CH_SPAN; i++) begin
				ch_seen[i] = 1'b0;
				ch_stable[i] = 1'b0;
				ch_last[i] = 1'b0;
				ch_prior[i] = 1'b0;
				ch_latched[i] = 1'b0;
				ch_change_t[i] = '0;
				ch_press_t[i] = '0;
				ch_release_t[i] = '0;
			end
			expected_events.delete();
			mismatches = 0;
			in_flight = 0;
		end else begin
			if (events.valid && events.ready) begin
				got = '{events.channel_out, events.stable_active, events.pressed,
					events.released, events.double_click, events.long_press};
				if (expected_events.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result on channel %0d with nothing outstanding",
							$realtime, got.channel_out);
				end else begin
					want = expected_events.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: mismatch expected ch=%0d st=%0b pr=%0b rl=%0b ",
								"dc=%0b lp=%0b got ch=%0d st=%0b pr=%0b rl=%0b dc=%0b lp=%0b"},
								$realtime, want.channel_out, want.stable_active,
								want.pressed, want.released, want.double_click,
								want.long_press, got.channel_out, got.stable_active,
								got.pressed, got.released, got.double_click,
								got.long_press);
					end
				end
			end
			if (samples.valid && samples.ready)
				expected_events.push_back(detect_events(samples.channel,
					samples.raw_level, samples.now_ms));
			// apply register writes after the sample so a same-edge sample sees the old value
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[PADDR_W-1:2]))
					REG_DEBOUNCE:     cfg.debounce_ms = pwdata[MS_W-1:0];
					REG_ACTIVE_HIGH:  cfg.active_high_mask = pwdata[MASK_W-1:0];
					REG_OVR_ENABLE:   cfg.override_enable_mask = pwdata[MASK_W-1:0];
					REG_OVR_VALUE:    cfg.override_value_mask = pwdata[MASK_W-1:0];
					REG_LONG_PRESS:   cfg.long_press_ms = pwdata[MS_W-1:0];
					REG_LP_ENABLE:    cfg.long_press_enable_mask = pwdata[MASK_W-1:0];
					REG_DOUBLE_CLICK: cfg.double_click_ms = pwdata[MS_W-1:0];
					default: ;
				endcase
			end
			in_flight = expected_events.size();
		end
	end

endmodule

### test/tb_multi_channel_button_event_detector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_channel_button_event_detector
// Drives pin samples and register writes into the button event detector.
// A directed run walks through press, release, double click at the window
// edge, long press, first samples, time wrap and manual override; random
// phases then sweep register settings, extremes included, with press and
// release sequences under bounce, random gaps and random result back-pressure.
// ----------------------------------------------------------------------------
module tb_multi_channel_button_event_detector;
	import bted_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	int                 mismatches;
	int                 in_flight;

	logic [CH_SPAN-1:0] pin_hold;
	logic [CH_W-1:0]    focus;
	logic [TIME_W-1:0]  t_now;
	int                 span;

	bted_sample_if sample_ch ();
	bted_event_if  event_ch ();

	multi_channel_button_event_detector dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (sample_ch),
		.events  (event_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	bted_event_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (sample_ch),
		.events     (event_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.mismatches (mismatches),
		.in_flight  (in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	// Result side: ready with short and long stalls, and calm stretches.
	initial begin : result_sink
		int stall;
		int calm;
		int r;
		stall = 0;
		calm = 0;
		event_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (calm > 0) begin
				calm--;
				event_ch.ready = 1'b1;
			end else if (stall > 0) begin
				stall--;
				event_ch.ready = 1'b0;
			end else begin
				event_ch.ready = 1'b1;
				r = $urandom_range(0, 99);
				if (r < 4)
					calm = $urandom_range(20, 120);
				else if (r < 6)
					stall = $urandom_range(10, 40);
				else if (r < 30)
					stall = $urandom_range(1, 3);
			end
		end
	end

	task automatic send_sample(logic [CH_W-1:0] ch, logic raw, logic [TIME_W-1:0] t);
		@(negedge clk);
		sample_ch.valid = 1'b1;
		sample_ch.channel = ch;
		sample_ch.raw_level = raw;
		sample_ch.now_ms = t;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Hold off the sender until every transfer has its result back.
	task automatic drain();
		@(negedge clk) sample_ch.valid = 1'b0;
		while (in_flight != 0) @(negedge clk);
	endtask

	task automatic apply_setting(int p);
		logic [MS_W-1:0]   db;
		logic [MS_W-1:0]   lp;
		logic [MS_W-1:0]   dc;
		logic [MASK_W-1:0] ah;
		logic [MASK_W-1:0] oe;
		logic [MASK_W-1:0] ov;
		logic [MASK_W-1:0] le;
		db = MS_W'($urandom_range(0, 120));
		ah = MASK_W'($urandom);
		oe = MASK_W'($urandom & $urandom & $urandom);
		ov = MASK_W'($urandom);
		lp = ($urandom_range(0, 9) == 0) ? '0 : MS_W'($urandom_range(1, 2500));
		le = MASK_W'($urandom);
		dc = MS_W'($urandom_range(0, 800));
		case (p)
			0: begin
				db = '0; ah = 8'hFF; oe = '0; lp = 16'd1; le = 8'hFF; dc = '0;
			end
			1: begin
				db = 16'hFFFF; ah = '0; oe = '0; lp = 16'hFFFF; le = 8'hFF; dc = 16'hFFFF;
			end
			2: begin
				db = 16'd20; oe = '0; le = '0; dc = 16'd300;
			end
			3: oe = 8'hFF;
			4: lp = '0;
			default: ;
		endcase
		write_reg(REG_DEBOUNCE, DATA_W'(db));
		write_reg(REG_ACTIVE_HIGH, DATA_W'(ah));
		write_reg(REG_OVR_ENABLE, DATA_W'(oe));
		write_reg(REG_OVR_VALUE, DATA_W'(ov));
		write_reg(REG_LONG_PRESS, DATA_W'(lp));
		write_reg(REG_LP_ENABLE, DATA_W'(le));
		write_reg(REG_DOUBLE_CLICK, DATA_W'(dc));
		span = 16;
		if (int'(db) > span) span = int'(db);
		if (int'(lp) > span) span = int'(lp);
		if (int'(dc) > span) span = int'(dc);
	endtask

	task automatic run_directed();
		send_sample(3'd0, 1'b0, 32'd0);     // active first sample after reset
		send_sample(3'd0, 1'b0, 32'd1000);  // long press at the exact hold time
		send_sample(3'd0, 1'b0, 32'd1500);  // no second long press in one hold
		send_sample(3'd0, 1'b1, 32'd1510);
		send_sample(3'd0, 1'b0, 32'd1520);  // bounce back
		send_sample(3'd0, 1'b1, 32'd1530);
		send_sample(3'd0, 1'b1, 32'd1580);  // release after the full debounce time
		send_sample(3'd0, 1'b0, 32'd2030);
		send_sample(3'd0, 1'b0, 32'd2080);  // double click on the window edge
		send_sample(3'd0, 1'b1, 32'd2100);
		send_sample(3'd0, 1'b1, 32'd2150);
		send_sample(3'd0, 1'b0, 32'd2601);
		send_sample(3'd0, 1'b0, 32'd2651);  // one past the window
		send_sample(3'd1, 1'b1, 32'hFFFF_FFC0);
		send_sample(3'd1, 1'b0, 32'hFFFF_FFF0);
		send_sample(3'd1, 1'b0, 32'h0000_0022); // debounce across the time wrap
		send_sample(3'd1, 1'b0, 32'h0000_040A);
		send_sample(3'd7, 1'b1, 32'hFFFF_FFFF);
		send_sample(3'd6, 1'b0, 32'd600);
		drain();
		write_reg(REG_OVR_ENABLE, 32'h03);
		write_reg(REG_OVR_VALUE, 32'h01);
		send_sample(3'd0, 1'b1, 32'd700);
		send_sample(3'd1, 1'b1, 32'd700);
		drain();
		write_reg(REG_OVR_VALUE, 32'h02);
		send_sample(3'd0, 1'b0, 32'd800);
		send_sample(3'd1, 1'b0, 32'd800);
		drain();
	endtask

	task automatic run_random(int count);
		logic [CH_W-1:0] ch;
		logic            raw;
		int              r;
		int              burst;
		int              gap;
		burst = 0;
		repeat (count) begin
			if ($urandom_range(0, 9) == 0)
				focus = CH_W'($urandom);
			ch = ($urandom_range(0, 99) < 70) ? focus : CH_W'($urandom);
			if ($urandom_range(0, 99) < 25)
				pin_hold[ch] = ~pin_hold[ch];
			raw = pin_hold[ch];
			if ($urandom_range(0, 99) < 12)
				raw = ~raw;
			r = $urandom_range(0, 99);
			if (r < 8)
				t_now += $urandom_range(0, 3);
			else if (r < 65)
				t_now += $urandom_range(0, span / 8 + 2);
			else if (r < 97)
				t_now += $urandom_range(0, span + span / 2 + 2);
			else
				t_now += $urandom;
			send_sample(ch, raw, t_now);
			gap = 0;
			if (burst > 0)
				burst--;
			else begin
				r = $urandom_range(0, 99);
				if (r < 30)
					burst = $urandom_range(5, 30);
				else if (r < 47)
					gap = $urandom_range(1, 3);
				else if (r < 50)
					gap = $urandom_range(8, 30);
			end
			repeat (gap) @(negedge clk) sample_ch.valid = 1'b0;
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.channel = '0;
		sample_ch.raw_level = 1'b0;
		sample_ch.now_ms = '0;
		pin_hold = '0;
		focus = '0;
		t_now = '0;
		span = 16;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		run_directed();
		for (int p = 0; p < 8; p++) begin
			drain();
			apply_setting(p);
			t_now = $urandom;
			run_random(80);
		end
		drain();
		repeat (10) @(negedge clk);
		if (mismatches == 0 && in_flight == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
